/* rtl/cpot_pkg.sv */
// ----------------------------------------------------------------------------
// cpot_pkg
// Shared types and constants of the collider pair overlap test pipeline.
// ----------------------------------------------------------------------------
package cpot_pkg;

  // field widths
  localparam int SizeW     = 16;
  localparam int ScaleW    = 10;
  localparam int ShapeW    = 2;
  localparam int OutDataW  = 8;
  localparam logic [ScaleW-1:0] ScaleReset = 10'd100;

  // positions are moved onto a 1/512 pixel grid (q.4 times 32)
  localparam int GridShift = 5;
  // internal coordinate width, covers position words of up to 32 bits
  localparam int CoordW    = 40;
  // scaled half size, radius (sum of two half sizes) and its square
  localparam int HalfW     = SizeW + ScaleW;
  localparam int RadW      = HalfW + 1;
  localparam int SqW       = 2 * RadW;

  typedef enum logic [1:0] {
    ModeRr,
    ModeCc,
    ModeCr
  } mode_e;

  typedef struct packed {
    logic                     lshape;
    logic                     rshape;
    logic signed [CoordW-1:0] lx;
    logic signed [CoordW-1:0] ly;
    logic signed [CoordW-1:0] rx;
    logic signed [CoordW-1:0] ry;
    logic [SizeW-1:0]         lwid;
    logic [SizeW-1:0]         lhgt;
    logic [SizeW-1:0]         rwid;
    logic [SizeW-1:0]         rhgt;
  } in_t;

  typedef struct packed {
    logic                     lshape;
    logic                     rshape;
    logic signed [CoordW-1:0] lx;
    logic signed [CoordW-1:0] ly;
    logic signed [CoordW-1:0] rx;
    logic signed [CoordW-1:0] ry;
    logic [HalfW-1:0]         lw;
    logic [HalfW-1:0]         lh;
    logic [HalfW-1:0]         rw;
    logic [HalfW-1:0]         rh;
  } scaled_t;

  typedef struct packed {
    mode_e                    mode;
    logic signed [CoordW-1:0] ax0;
    logic signed [CoordW-1:0] bx0;
    logic signed [CoordW-1:0] ay0;
    logic signed [CoordW-1:0] by0;
    logic [RadW-1:0]          r;
    logic [RadW-1:0]          sy;
  } geom_t;

  typedef struct packed {
    mode_e             mode;
    logic [CoordW-1:0] ax;
    logic [CoordW-1:0] ay;
    logic [RadW-1:0]   r;
    logic [RadW-1:0]   sy;
  } dist_t;

  typedef struct packed {
    mode_e          mode;
    logic           far;
    logic           rr_hit;
    logic [SqW-1:0] sqx;
    logic [SqW-1:0] sqy;
    logic [SqW-1:0] rsq;
  } square_t;

  function automatic logic signed [CoordW-1:0] ext_half(input logic [HalfW-1:0] h);
    return $signed({{(CoordW-HalfW){1'b0}}, h});
  endfunction

endpackage

/* rtl/collider_pair_overlap_test_top.sv */
// ----------------------------------------------------------------------------
// collider_pair_overlap_test_top
// Overlap test of two 2d colliders (rectangle or circle) per word.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one collider pair per word: both shapes in tuser, both
//   positions (q.4 px) and sizes (q8.8 units) in tdata. m_axis returns one
//   word per pair with the overlap flag in tdata bit 0.
//   cfg_we_i/cfg_wdata_i write pixels per size unit; write it only while
//   no pair is in flight.
//   m_axis_tvalid comes from the last of five register stages. Unless
//   m_axis stalls, one pair is taken every cycle: scale multiply, box
//   clamp, distance, squaring and final compare each hold one register
//   stage.
//   Every stage moves on when its successor is empty or moving, so a stall
//   on m_axis fills the pipeline before s_axis_tready drops, and bubbles
//   are squeezed out; nothing is dropped or repeated.
//   Reset empties all stages and sets pixels per size unit to 100.
// ----------------------------------------------------------------------------
module collider_pair_overlap_test_top #(
  parameter int  POSITION_BITS = 24,
  localparam int InDataW = ((4 * POSITION_BITS + 4 * cpot_pkg::SizeW + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cpot_pkg::ScaleW-1:0]   cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // left_x, left_y, left_width, left_height, right_x, right_y, right_width,
  // right_height, zero pad
  input  logic [InDataW-1:0]            s_axis_tdata,
  // left_shape, right_shape
  input  logic [cpot_pkg::ShapeW-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // overlap, zero pad
  output logic [cpot_pkg::OutDataW-1:0] m_axis_tdata
);
  import cpot_pkg::*;

  localparam int PB = POSITION_BITS;

  logic [ScaleW-1:0] scale_q;
  in_t               in_word;
  logic [PB-1:0]     left_x, left_y, right_x, right_y;

  logic    scale_valid, scale_ready;
  scaled_t scale_data;
  logic    geom_valid, geom_ready;
  geom_t   geom_data;
  logic    dist_valid, dist_ready;
  dist_t   dist_data;
  logic    overlap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  assign left_x  = s_axis_tdata[0 +: PB];
  assign left_y  = s_axis_tdata[PB +: PB];
  assign right_x = s_axis_tdata[2*PB + 2*SizeW +: PB];
  assign right_y = s_axis_tdata[3*PB + 2*SizeW +: PB];

  // sign extend and move onto the 1/512 px grid
  always_comb begin
    in_word.lshape = s_axis_tuser[0];
    in_word.rshape = s_axis_tuser[1];
    in_word.lx     = {{(CoordW-PB-GridShift){left_x[PB-1]}},  left_x,  {GridShift{1'b0}}};
    in_word.ly     = {{(CoordW-PB-GridShift){left_y[PB-1]}},  left_y,  {GridShift{1'b0}}};
    in_word.rx     = {{(CoordW-PB-GridShift){right_x[PB-1]}}, right_x, {GridShift{1'b0}}};
    in_word.ry     = {{(CoordW-PB-GridShift){right_y[PB-1]}}, right_y, {GridShift{1'b0}}};
    in_word.lwid   = s_axis_tdata[2*PB +: SizeW];
    in_word.lhgt   = s_axis_tdata[2*PB + SizeW +: SizeW];
    in_word.rwid   = s_axis_tdata[4*PB + 2*SizeW +: SizeW];
    in_word.rhgt   = s_axis_tdata[4*PB + 3*SizeW +: SizeW];
  end

  cpot_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .scale_i (scale_q),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (in_word),
    .valid_o (scale_valid),
    .ready_i (scale_ready),
    .data_o  (scale_data)
  );

  cpot_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scale_valid),
    .ready_o (scale_ready),
    .data_i  (scale_data),
    .valid_o (geom_valid),
    .ready_i (geom_ready),
    .data_o  (geom_data)
  );

  cpot_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (geom_valid),
    .ready_o (geom_ready),
    .data_i  (geom_data),
    .valid_o (dist_valid),
    .ready_i (dist_ready),
    .data_o  (dist_data)
  );

  cpot_decide u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dist_valid),
    .ready_o (dist_ready),
    .data_i  (dist_data),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .hit_o   (overlap)
  );

  assign m_axis_tdata = {{(OutDataW-1){1'b0}}, overlap};

endmodule

/* rtl/cpot_scale.sv */
// ----------------------------------------------------------------------------
// cpot_scale
// First stage: turns the four sizes into half extents on the fine grid.
// ----------------------------------------------------------------------------
module cpot_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [cpot_pkg::ScaleW-1:0] scale_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  cpot_pkg::in_t               data_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output cpot_pkg::scaled_t           data_o
);
  import cpot_pkg::*;

  logic    valid_q;
  scaled_t data_d, data_q;
  logic [HalfW-1:0] scale_ext;

  assign ready_o   = !valid_q || ready_i;
  assign scale_ext = {{(HalfW-ScaleW){1'b0}}, scale_i};

  // size (q8.8 units) times pixels per unit is exactly a half size in 1/512 px
  always_comb begin
    data_d.lshape = data_i.lshape;
    data_d.rshape = data_i.rshape;
    data_d.lx     = data_i.lx;
    data_d.ly     = data_i.ly;
    data_d.rx     = data_i.rx;
    data_d.ry     = data_i.ry;
    data_d.lw     = {{(HalfW-SizeW){1'b0}}, data_i.lwid} * scale_ext;
    data_d.lh     = {{(HalfW-SizeW){1'b0}}, data_i.lhgt} * scale_ext;
    data_d.rw     = {{(HalfW-SizeW){1'b0}}, data_i.rwid} * scale_ext;
    data_d.rh     = {{(HalfW-SizeW){1'b0}}, data_i.rhgt} * scale_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/cpot_geom.sv */
// ----------------------------------------------------------------------------
// cpot_geom
// Second stage: picks the test and lines up the two points to subtract,
// clamping the circle centre into the box for the mixed case.
// ----------------------------------------------------------------------------
module cpot_geom (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  cpot_pkg::scaled_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output cpot_pkg::geom_t   data_o
);
  import cpot_pkg::*;

  logic  valid_q;
  geom_t data_d, data_q;

  logic signed [CoordW-1:0] lw_s, lh_s, rw_s, rh_s;
  logic signed [CoordW-1:0] cx, cy, bx, by, bw_s, bh_s;
  logic signed [CoordW-1:0] hix, lox, hiy, loy, px, py;
  logic [HalfW-1:0]         cr;

  assign ready_o = !valid_q || ready_i;

  assign lw_s = ext_half(data_i.lw);
  assign lh_s = ext_half(data_i.lh);
  assign rw_s = ext_half(data_i.rw);
  assign rh_s = ext_half(data_i.rh);

  // mixed case: the circle may be on either side
  assign cx   = data_i.lshape ? data_i.lx : data_i.rx;
  assign cy   = data_i.lshape ? data_i.ly : data_i.ry;
  assign cr   = data_i.lshape ? data_i.lw : data_i.rw;
  assign bx   = data_i.lshape ? data_i.rx : data_i.lx;
  assign by   = data_i.lshape ? data_i.ry : data_i.ly;
  assign bw_s = data_i.lshape ? rw_s : lw_s;
  assign bh_s = data_i.lshape ? rh_s : lh_s;

  assign hix = bx + bw_s;
  assign lox = bx - bw_s;
  assign hiy = by + bh_s;
  assign loy = by - bh_s;
  assign px  = (cx > hix) ? hix : ((cx < lox) ? lox : cx);
  assign py  = (cy > hiy) ? hiy : ((cy < loy) ? loy : cy);

  always_comb begin
    data_d.sy = {1'b0, data_i.lh} + {1'b0, data_i.rh};
    data_d.r  = {1'b0, data_i.lw} + {1'b0, data_i.rw};
    if (!data_i.lshape && !data_i.rshape) begin
      data_d.mode = ModeRr;
      data_d.ax0  = data_i.lx;
      data_d.bx0  = data_i.rx;
      data_d.ay0  = data_i.ly;
      data_d.by0  = data_i.ry;
    end else if (data_i.lshape && data_i.rshape) begin
      // circle centres sit at position plus half size
      data_d.mode = ModeCc;
      data_d.ax0  = data_i.lx + lw_s;
      data_d.bx0  = data_i.rx + rw_s;
      data_d.ay0  = data_i.ly + lh_s;
      data_d.by0  = data_i.ry + rh_s;
    end else begin
      data_d.mode = ModeCr;
      data_d.ax0  = cx;
      data_d.bx0  = px;
      data_d.ay0  = cy;
      data_d.by0  = py;
      data_d.r    = {1'b0, cr};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/cpot_dist.sv */
// ----------------------------------------------------------------------------
// cpot_dist
// Third stage: per-axis distance magnitudes.
// ----------------------------------------------------------------------------
module cpot_dist (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  cpot_pkg::geom_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output cpot_pkg::dist_t data_o
);
  import cpot_pkg::*;

  logic  valid_q;
  dist_t data_d, data_q;
  logic signed [CoordW-1:0] dx, dy;

  assign ready_o = !valid_q || ready_i;

  // operands stay well inside the coordinate width, so no wrap here
  assign dx = data_i.ax0 - data_i.bx0;
  assign dy = data_i.ay0 - data_i.by0;

  always_comb begin
    data_d.mode = data_i.mode;
    data_d.ax   = dx[CoordW-1] ? $unsigned(-dx) : $unsigned(dx);
    data_d.ay   = dy[CoordW-1] ? $unsigned(-dy) : $unsigned(dy);
    data_d.r    = data_i.r;
    data_d.sy   = data_i.sy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/cpot_decide.sv */
// ----------------------------------------------------------------------------
// cpot_decide
// Last two stages: squares and bounds, then the final compare into the
// output register.
// ----------------------------------------------------------------------------
module cpot_decide (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  cpot_pkg::dist_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic            hit_o
);
  import cpot_pkg::*;

  logic    sq_valid_q, sq_ready;
  square_t sq_d, sq_q;
  logic    out_valid_q;
  logic    hit_d, hit_q;

  logic [CoordW-1:0] r_ext, sy_ext;
  logic [RadW-1:0]   mx, my;
  logic [SqW:0]      dist_sq;

  assign ready_o  = !sq_valid_q || sq_ready;
  assign sq_ready = !out_valid_q || ready_i;

  assign r_ext  = {{(CoordW-RadW){1'b0}}, data_i.r};
  assign sy_ext = {{(CoordW-RadW){1'b0}}, data_i.sy};
  // only the low bits matter once the far check has passed
  assign mx = data_i.ax[RadW-1:0];
  assign my = data_i.ay[RadW-1:0];

  always_comb begin
    sq_d.mode   = data_i.mode;
    sq_d.far    = (data_i.ax > r_ext) || (data_i.ay > r_ext);
    sq_d.rr_hit = (data_i.ax < r_ext) && (data_i.ay < sy_ext);
    sq_d.sqx    = {{(SqW-RadW){1'b0}}, mx} * {{(SqW-RadW){1'b0}}, mx};
    sq_d.sqy    = {{(SqW-RadW){1'b0}}, my} * {{(SqW-RadW){1'b0}}, my};
    sq_d.rsq    = {{(SqW-RadW){1'b0}}, data_i.r} * {{(SqW-RadW){1'b0}}, data_i.r};
  end

  assign dist_sq = {1'b0, sq_q.sqx} + {1'b0, sq_q.sqy};

  always_comb begin
    case (sq_q.mode)
      ModeRr:  hit_d = sq_q.rr_hit;
      default: hit_d = !sq_q.far && (dist_sq <= {1'b0, sq_q.rsq});
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        sq_valid_q <= valid_i;
      end
      if (sq_ready) begin
        out_valid_q <= sq_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sq_q <= sq_d;
    end
    if (sq_valid_q && sq_ready) begin
      hit_q <= hit_d;
    end
  end

  assign valid_o = out_valid_q;
  assign hit_o   = hit_q;

  a_word_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid_q && sq_ready |=> out_valid_q)
    else $error("squared stage word did not reach the output register");

  a_rect_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid_q && sq_ready && sq_q.mode == ModeRr |=> hit_q == $past(sq_q.rr_hit))
    else $error("rectangle pair result differs from the bound check");

  a_far_circle_misses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid_q && sq_ready && sq_q.mode != ModeRr && sq_q.far |=> !hit_q)
    else $error("circle test reported overlap beyond the radius");

endmodule
